/* rtl/fadc_record_lane_decoder_assert.svh */
// Assertion macros for the lane decoder RTL, included by fadc_queue.
// Clock i_clk and active-low reset i_rst_n are taken from the using module.
`ifndef FADC_RECORD_LANE_DECODER_ASSERT_SVH
`define FADC_RECORD_LANE_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define FADC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("fadc assertion failed");
`define FADC_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("fadc forbidden condition");
`else
`define FADC_ASSERT(lbl, prop)
`define FADC_NEVER(lbl, cond)
`endif
`endif

/* rtl/fadc_pkg.sv */
// Shared types and constants for the digitizer record lane decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fadc_pkg;
    localparam int LANES        = 4;
    localparam int HEADER_BYTES = 32;
    localparam int Q_DEPTH      = 2;

    localparam logic [3:0] K_LENGTH     = 4'd0;
    localparam logic [3:0] K_TRIGTYPE   = 4'd1;
    localparam logic [3:0] K_TRIGNUM    = 4'd2;
    localparam logic [3:0] K_TRIGTIME   = 4'd3;
    localparam logic [3:0] K_MODULE     = 4'd4;
    localparam logic [3:0] K_CHANID     = 4'd5;
    localparam logic [3:0] K_LOCTRIGNUM = 4'd6;
    localparam logic [3:0] K_LOCPATTERN = 4'd7;
    localparam logic [3:0] K_PEDESTAL   = 4'd8;
    localparam logic [3:0] K_STARTTIME  = 4'd9;
    localparam logic [3:0] K_ADC        = 4'd10;
    localparam logic [3:0] K_TDC        = 4'd11;

    localparam logic CFG_RECORD_LENGTH = 1'b0;
    localparam logic CFG_FLIP_ADC      = 1'b1;

    typedef logic [LANES-1:0][HEADER_BYTES-1:0][7:0] t_hdr;

    typedef struct packed {
        logic                   hdr;
        logic                   tdc;
        logic [14:0]            sidx;
        logic [12:0]            group;
        logic [LANES-1:0][11:0] adc;
        logic [LANES-1:0][11:0] tdcv;
    } t_entry;
endpackage
`default_nettype wire

/* rtl/fadc_front.sv */
// Front end: config registers, byte position tracking, header shift line,
// ADC/TDC assembly. Pushes one queue entry per result-producing word. Uses fadc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fadc_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [fadc_pkg::LANES-1:0][7:0] i_bytes,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_index,
    input  wire logic [15:0]                     i_cfg_data,
    input  wire logic                            i_q_ready,
    output logic                                 o_q_push,
    output fadc_pkg::t_entry                     o_q_entry,
    input  wire logic                            i_hdr_done,
    output fadc_pkg::t_hdr                       o_hdr
);
    logic [15:0] r_len_cfg;
    logic        r_flip;
    logic [15:0] r_pos;
    logic        r_busy;
    fadc_pkg::t_hdr r_hdr;
    logic [fadc_pkg::LANES-1:0][7:0] r_adc_lo;
    logic [fadc_pkg::LANES-1:0][7:0] r_tdc_part;

    logic [15:0] len, p, b;
    logic        in_hdr, acc, is_odd, tdc_ok;
    logic [16:0] grp_end;

    always_comb begin
        len     = (r_len_cfg < 16'(fadc_pkg::HEADER_BYTES)) ?
                  16'(fadc_pkg::HEADER_BYTES) : r_len_cfg;
        p       = (r_pos >= len) ? 16'd0 : r_pos;
        in_hdr  = p < 16'(fadc_pkg::HEADER_BYTES);
        b       = p - 16'(fadc_pkg::HEADER_BYTES);
        is_odd  = b[0];
        grp_end = {1'b0, b[15:3], 3'b000} + 17'(fadc_pkg::HEADER_BYTES + 8);
        tdc_ok  = grp_end <= {1'b0, len};
        o_ready = i_q_ready && !(in_hdr && r_busy);
        acc     = i_valid && o_ready;
        o_q_push = acc && (in_hdr ? (p == 16'(fadc_pkg::HEADER_BYTES - 1)) : is_odd);
        o_q_entry.hdr   = in_hdr;
        o_q_entry.tdc   = (b[2:0] == 3'd5) && tdc_ok;
        o_q_entry.sidx  = b[15:1];
        o_q_entry.group = b[15:3];
        for (int l = 0; l < fadc_pkg::LANES; l++) begin
            o_q_entry.adc[l]  = {i_bytes[l][3:0], r_adc_lo[l]} ^ {12{r_flip}};
            o_q_entry.tdcv[l] = {i_bytes[l][7:4], r_tdc_part[l]};
        end
        o_hdr = r_hdr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_cfg <= 16'd544;
            r_flip    <= 1'b1;
            r_pos     <= '0;
            r_busy    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == fadc_pkg::CFG_RECORD_LENGTH) r_len_cfg <= i_cfg_data;
                else r_flip <= i_cfg_data[0];
            end
            if (acc) begin
                r_pos <= (p + 16'd1 >= len) ? 16'd0 : p + 16'd1;
            end
            if (o_q_push && in_hdr) r_busy <= 1'b1;
            else if (i_hdr_done) r_busy <= 1'b0;
        end
    end

    // payload: header shift line and per-lane partial words
    always_ff @(posedge i_clk) begin
        if (acc) begin
            for (int l = 0; l < fadc_pkg::LANES; l++) begin
                if (in_hdr) begin
                    r_hdr[l][fadc_pkg::HEADER_BYTES-1] <= i_bytes[l];
                    for (int k = 0; k < fadc_pkg::HEADER_BYTES - 1; k++)
                        r_hdr[l][k] <= r_hdr[l][k+1];
                end else begin
                    if (!is_odd) r_adc_lo[l] <= i_bytes[l];
                    if (b[2:0] == 3'd1) r_tdc_part[l] <= {4'h0, i_bytes[l][7:4]};
                    else if (b[2:0] == 3'd3)
                        r_tdc_part[l] <= {i_bytes[l][7:4], r_tdc_part[l][3:0]};
                end
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/fadc_queue.sv */
// Two-entry queue between the front end and the result sequencer.
// Uses fadc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "fadc_record_lane_decoder_assert.svh"
module fadc_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire fadc_pkg::t_entry i_entry,
    output logic                  o_ready,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output fadc_pkg::t_entry      o_entry
);
    fadc_pkg::t_entry r_mem [fadc_pkg::Q_DEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_ready = r_cnt != 2'(fadc_pkg::Q_DEPTH);
    assign o_valid = r_cnt != 2'd0;
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

    `FADC_NEVER(a_push_full, i_push && !o_ready)
    `FADC_NEVER(a_pop_empty, i_pop && !o_valid)
    `FADC_ASSERT(a_cnt_range, r_cnt <= 2'(fadc_pkg::Q_DEPTH))
endmodule
`default_nettype wire

/* rtl/fadc_back.sv */
// Result sequencer: expands queue entries into header fields, ADC and TDC
// results through a registered output stage. Uses fadc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fadc_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire fadc_pkg::t_entry i_entry,
    output logic                  o_q_pop,
    output logic                  o_hdr_done,
    input  wire fadc_pkg::t_hdr   i_hdr,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [3:0]            o_kind,
    output logic [1:0]            o_lane,
    output logic [14:0]           o_sample_index,
    output logic [57:0]           o_value,
    output logic                  o_bad_channel_id,
    output logic                  o_last
);
    localparam int HEADER_W = fadc_pkg::HEADER_BYTES * 8;

    logic [1:0]  r_lane;
    logic [3:0]  r_fld;
    logic        r_phase;
    logic        r_ovalid;
    logic [3:0]  r_kind;
    logic [1:0]  r_olane;
    logic [14:0] r_sidx;
    logic [57:0] r_value;
    logic        r_bad, r_last;

    logic take, last;
    logic [3:0]  n_kind;
    logic [14:0] n_sidx;
    logic [57:0] n_value;
    logic        n_bad;
    logic [HEADER_W-1:0] hb;
    logic [47:0] coarse;
    logic [7:0]  fine;

    always_comb begin
        take = i_q_valid && (!r_ovalid || i_ready);
        hb   = i_hdr[r_lane];
        last = (r_lane == 2'(fadc_pkg::LANES - 1)) &&
               (i_entry.hdr ? (r_fld == fadc_pkg::K_STARTTIME)
                            : (r_phase || !i_entry.tdc));
        coarse = (r_fld == fadc_pkg::K_TRIGTIME) ? {24'd0, hb[119:96]} : hb[255:208];
        fine   = (r_fld == fadc_pkg::K_TRIGTIME) ? hb[95:88] : hb[207:200];
        n_bad  = 1'b0;
        n_value = '0;
        if (i_entry.hdr) begin
            n_kind = r_fld;
            n_sidx = '0;
            case (r_fld)
                fadc_pkg::K_LENGTH:     n_value = 58'(hb[31:0]);
                fadc_pkg::K_TRIGTYPE:   n_value = 58'(hb[51:48]);
                fadc_pkg::K_TRIGNUM:    n_value = 58'(hb[87:56]);
                fadc_pkg::K_MODULE:     n_value = 58'(hb[127:120]);
                fadc_pkg::K_CHANID: begin
                    n_value = 58'(hb[135:128]);
                    n_bad   = (hb[135:128] < 8'd1) || (hb[135:128] > 8'd4);
                end
                fadc_pkg::K_LOCTRIGNUM: n_value = 58'(hb[167:136]);
                fadc_pkg::K_LOCPATTERN: n_value = 58'(hb[183:168]);
                fadc_pkg::K_PEDESTAL:   n_value = 58'(hb[199:184]);
                fadc_pkg::K_TRIGTIME, fadc_pkg::K_STARTTIME:
                    // x*1000 = x*1024 - x*32 + x*8
                    n_value = (58'(coarse) << 10) - (58'(coarse) << 5)
                            + (58'(coarse) << 3) + (58'(fine) << 3);
                default:                n_value = '0;
            endcase
        end else if (r_phase) begin
            n_kind  = fadc_pkg::K_TDC;
            n_sidx  = 15'(i_entry.group);
            n_value = 58'(i_entry.tdcv[r_lane]);
        end else begin
            n_kind  = fadc_pkg::K_ADC;
            n_sidx  = i_entry.sidx;
            n_value = 58'(i_entry.adc[r_lane]);
        end
        o_q_pop    = take && last;
        o_hdr_done = take && last && i_entry.hdr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane   <= '0;
            r_fld    <= '0;
            r_phase  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (take) begin
                r_ovalid <= 1'b1;
                if (last) begin
                    r_lane  <= '0;
                    r_fld   <= '0;
                    r_phase <= 1'b0;
                end else if (i_entry.hdr) begin
                    if (r_fld == fadc_pkg::K_STARTTIME) begin
                        r_fld  <= '0;
                        r_lane <= r_lane + 2'd1;
                    end else begin
                        r_fld <= r_fld + 4'd1;
                    end
                end else if (r_lane == 2'(fadc_pkg::LANES - 1)) begin
                    r_lane  <= '0;
                    r_phase <= 1'b1;
                end else begin
                    r_lane <= r_lane + 2'd1;
                end
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_kind  <= n_kind;
            r_olane <= r_lane;
            r_sidx  <= n_sidx;
            r_value <= n_value;
            r_bad   <= n_bad;
            r_last  <= last;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_kind           = r_kind;
    assign o_lane           = r_olane;
    assign o_sample_index   = r_sidx;
    assign o_value          = r_value;
    assign o_bad_channel_id = r_bad;
    assign o_last           = r_last;
endmodule
`default_nettype wire

/* rtl/fadc_record_lane_decoder.sv */
// Top level of the digitizer record lane decoder.
// Depends on fadc_pkg, fadc_front, fadc_queue and fadc_back.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------------
//  input    | in        | i_valid / o_ready     | i_lane0_byte .. i_lane3_byte
//  result   | out       | o_valid / i_ready     | kind, lane, sample_index, value, ...
//  config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Words are taken one per cycle while the queue has room; every word that yields
// results pushes one entry into a two-entry queue, and the result sequencer drains
// it one result per cycle while i_ready is high: 40 for a header, 4 for an odd body
// word, 8 when a TDC group closes. The output port therefore sets the long-run pace
// of result-producing words. Header words of a new record wait until the previous
// header run has been emitted, since the header shift line is read by the sequencer.
// Reset (synchronous, active low) clears position, queue and sequencer; config
// returns to length 544 and ADC flip on. Config writes are always ready.
`timescale 1ns / 1ps
`default_nettype none
module fadc_record_lane_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_lane0_byte,
    input  wire logic [7:0]  i_lane1_byte,
    input  wire logic [7:0]  i_lane2_byte,
    input  wire logic [7:0]  i_lane3_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_kind,
    output logic [1:0]       o_lane,
    output logic [14:0]      o_sample_index,
    output logic [57:0]      o_value,
    output logic             o_bad_channel_id,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    logic [fadc_pkg::LANES-1:0][7:0] bytes;
    logic             q_ready, q_push, q_valid, q_pop, hdr_done;
    fadc_pkg::t_entry push_entry, head_entry;
    fadc_pkg::t_hdr   hdr;

    assign bytes       = {i_lane3_byte, i_lane2_byte, i_lane1_byte, i_lane0_byte};
    assign o_cfg_ready = 1'b1;

    // front: classify words, build ADC/TDC values, hold header bytes
    fadc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_bytes     (bytes),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_ready   (q_ready),
        .o_q_push    (q_push),
        .o_q_entry   (push_entry),
        .i_hdr_done  (hdr_done),
        .o_hdr       (hdr)
    );

    fadc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    // back: one result per cycle while i_ready allows, into the output register
    fadc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_entry          (head_entry),
        .o_q_pop          (q_pop),
        .o_hdr_done       (hdr_done),
        .i_hdr            (hdr),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_lane           (o_lane),
        .o_sample_index   (o_sample_index),
        .o_value          (o_value),
        .o_bad_channel_id (o_bad_channel_id),
        .o_last           (o_last)
    );
endmodule
`default_nettype wire
